[src/i2cm_pkg.sv]
// Package for the I2C master register front end.
// Holds the shared item types, register offsets and command codes.
// No dependencies.
`default_nettype none

package i2cm_pkg;

    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_ACK   = 2'd2,
        OP_BYTE  = 2'd3
    } op_kind_t;

    typedef enum logic [3:0] {
        SEL_NONE,
        SEL_VERID,
        SEL_PARAM,
        SEL_CTRL,
        SEL_STAT,
        SEL_IER,
        SEL_CFG,
        SEL_FSR,
        SEL_CMD,
        SEL_RDR
    } reg_sel_t;

    typedef struct packed {
        op_kind_t    kind;
        reg_sel_t    sel;
        logic [31:0] wdata;
        logic        nack;
        logic [7:0]  rx_byte;
    } item_t;

    localparam logic [15:0] OFF_VERID = 16'h0000;
    localparam logic [15:0] OFF_PARAM = 16'h0004;
    localparam logic [15:0] OFF_CTRL  = 16'h0010;
    localparam logic [15:0] OFF_STAT  = 16'h0014;
    localparam logic [15:0] OFF_IER   = 16'h0018;
    localparam logic [15:0] OFF_CFG   = 16'h0024;
    localparam logic [15:0] OFF_FSR   = 16'h005C;
    localparam logic [15:0] OFF_CMD   = 16'h0060;
    localparam logic [15:0] OFF_RDR   = 16'h0070;

    localparam logic [31:0] VERID_VAL    = 32'h0100_0003;
    localparam logic [31:0] PARAM_VAL    = 32'h0000_0303;
    localparam logic [31:0] CTL_MOMENT   = 32'h0000_0302;
    localparam logic [31:0] ST_TXREADY   = 32'h0000_0001;
    localparam logic [31:0] ST_RXREADY   = 32'h0000_0002;
    localparam logic [31:0] ST_END       = 32'h0000_0100;
    localparam logic [31:0] ST_STOP      = 32'h0000_0200;
    localparam logic [31:0] ST_NACK      = 32'h0000_0400;
    localparam logic [31:0] ST_BUSY      = 32'h0300_0000;
    localparam logic [31:0] ST_W1C       = 32'h0000_7F00;
    localparam logic [31:0] RX_EMPTY_VAL = 32'h0000_4000;
    localparam logic [31:0] FSR_MASK     = 32'h0000_007F;

    localparam int CTL_ENABLE_BIT  = 0;
    localparam int CTL_RXRESET_BIT = 9;

    localparam logic [2:0] CMD_SEND  = 3'd0;
    localparam logic [2:0] CMD_RECV  = 3'd1;
    localparam logic [2:0] CMD_STOP  = 3'd2;
    localparam logic [2:0] CMD_START = 3'd4;

    localparam logic [2:0] BUS_NONE  = 3'd0;
    localparam logic [2:0] BUS_START = 3'd1;
    localparam logic [2:0] BUS_SEND  = 3'd2;
    localparam logic [2:0] BUS_RECV  = 3'd3;
    localparam logic [2:0] BUS_STOP  = 3'd4;

endpackage

`default_nettype wire

[src/i2cm_front.sv]
// Front end: accepts requests, decodes the register offset and queues
// the classified items in a two-entry queue. Depends on i2cm_pkg.
`default_nettype none

module i2cm_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [1:0]       op,
    input  wire logic [15:0]      reg_offset,
    input  wire logic [31:0]      write_data,
    input  wire logic             bus_nack,
    input  wire logic [7:0]       bus_byte,
    output logic                  q_valid,
    output i2cm_pkg::item_t       q_item,
    input  wire logic             q_pop
);

    i2cm_pkg::item_t entry_reg [2];
    logic            head_reg, head_next;
    logic [1:0]      count_reg, count_next;
    i2cm_pkg::item_t new_item;
    i2cm_pkg::reg_sel_t sel;
    logic            push;
    logic            tail;

    always_comb
    begin
        unique case (reg_offset)
            i2cm_pkg::OFF_VERID: sel = i2cm_pkg::SEL_VERID;
            i2cm_pkg::OFF_PARAM: sel = i2cm_pkg::SEL_PARAM;
            i2cm_pkg::OFF_CTRL:  sel = i2cm_pkg::SEL_CTRL;
            i2cm_pkg::OFF_STAT:  sel = i2cm_pkg::SEL_STAT;
            i2cm_pkg::OFF_IER:   sel = i2cm_pkg::SEL_IER;
            i2cm_pkg::OFF_CFG:   sel = i2cm_pkg::SEL_CFG;
            i2cm_pkg::OFF_FSR:   sel = i2cm_pkg::SEL_FSR;
            i2cm_pkg::OFF_CMD:   sel = i2cm_pkg::SEL_CMD;
            i2cm_pkg::OFF_RDR:   sel = i2cm_pkg::SEL_RDR;
            default:             sel = i2cm_pkg::SEL_NONE;
        endcase
    end

    always_comb
    begin
        new_item.kind    = i2cm_pkg::op_kind_t'(op);
        new_item.sel     = sel;
        new_item.wdata   = write_data;
        new_item.nack    = bus_nack;
        new_item.rx_byte = bus_byte;
    end

    assign in_ready = (count_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign tail     = head_reg ^ count_reg[0];
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = entry_reg[head_reg];

    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        if (q_pop)
        begin
            head_next = ~head_reg;
        end
        unique case ({push, q_pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[tail] <= new_item;
        end
    end

endmodule

`default_nettype wire

[src/i2cm_back.sv]
// Back end: executes queued items against the control, status and config
// words, the pending command and the receive FIFO, and registers the result.
// Depends on i2cm_pkg.
`default_nettype none

module i2cm_back #(
    parameter int RX_DEPTH = 256
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             q_valid,
    input  wire i2cm_pkg::item_t  q_item,
    output logic                  q_pop,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic [31:0]           read_data,
    output logic [2:0]            bus_cmd,
    output logic [7:0]            bus_data
);

    localparam int PTR_W  = $clog2(RX_DEPTH);
    localparam int FILL_W = $clog2(RX_DEPTH + 1);

    typedef enum logic [1:0] {
        PEND_NONE,
        PEND_START,
        PEND_SEND,
        PEND_RECV
    } pend_t;

    logic [31:0]       ctrl_reg, ctrl_next;
    logic [31:0]       stat_reg, stat_next;
    logic [31:0]       cfg_reg, cfg_next;
    pend_t             pend_reg, pend_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic              out_valid_reg, out_valid_next;
    logic [31:0]       read_data_reg, read_data_next;
    logic [2:0]        bus_cmd_reg, bus_cmd_next;
    logic [7:0]        bus_data_reg, bus_data_next;
    logic              pop_reg, pop_next;
    logic [7:0]        mem_q_reg;
    logic [7:0]        rx_mem [RX_DEPTH];
    logic              fire;
    logic              pop_en;
    logic              wr_en;
    logic              fill_full;
    logic              fill_empty;
    logic [PTR_W-1:0]  rd_ptr_inc;
    logic [PTR_W-1:0]  wr_ptr_inc;
    logic [2:0]        cmd_code;

    assign fire       = q_valid && (!out_valid_reg || out_ready);
    assign q_pop      = fire;
    assign fill_full  = (fill_reg == FILL_W'(RX_DEPTH));
    assign fill_empty = (fill_reg == '0);
    assign rd_ptr_inc = (rd_ptr_reg == PTR_W'(RX_DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
    assign wr_ptr_inc = (wr_ptr_reg == PTR_W'(RX_DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
    assign cmd_code   = q_item.wdata[10:8];

    always_comb
    begin
        ctrl_next      = ctrl_reg;
        stat_next      = stat_reg;
        cfg_next       = cfg_reg;
        pend_next      = pend_reg;
        rd_ptr_next    = rd_ptr_reg;
        wr_ptr_next    = wr_ptr_reg;
        fill_next      = fill_reg;
        read_data_next = read_data_reg;
        bus_cmd_next   = bus_cmd_reg;
        bus_data_next  = bus_data_reg;
        pop_next       = pop_reg;
        pop_en         = 1'b0;
        wr_en          = 1'b0;

        if (fire)
        begin
            read_data_next = '0;
            bus_cmd_next   = i2cm_pkg::BUS_NONE;
            bus_data_next  = '0;
            pop_next       = 1'b0;
            unique case (q_item.kind)
                i2cm_pkg::OP_READ:
                begin
                    unique case (q_item.sel)
                        i2cm_pkg::SEL_VERID: read_data_next = i2cm_pkg::VERID_VAL;
                        i2cm_pkg::SEL_PARAM: read_data_next = i2cm_pkg::PARAM_VAL;
                        i2cm_pkg::SEL_CTRL:  read_data_next = ctrl_reg;
                        i2cm_pkg::SEL_STAT:
                        begin
                            read_data_next = stat_reg | i2cm_pkg::ST_TXREADY
                                | (fill_empty ? 32'd0 : i2cm_pkg::ST_RXREADY);
                        end
                        i2cm_pkg::SEL_CFG:   read_data_next = cfg_reg;
                        i2cm_pkg::SEL_FSR:
                        begin
                            read_data_next = (32'(fill_reg) & i2cm_pkg::FSR_MASK) << 16;
                        end
                        i2cm_pkg::SEL_RDR:
                        begin
                            if (fill_empty)
                            begin
                                read_data_next = i2cm_pkg::RX_EMPTY_VAL;
                            end
                            else
                            begin
                                pop_en      = 1'b1;
                                pop_next    = 1'b1;
                                rd_ptr_next = rd_ptr_inc;
                                fill_next   = fill_reg - FILL_W'(1);
                            end
                        end
                        default:             read_data_next = '0;
                    endcase
                end
                i2cm_pkg::OP_WRITE:
                begin
                    unique case (q_item.sel)
                        i2cm_pkg::SEL_CTRL:
                        begin
                            if (q_item.wdata[i2cm_pkg::CTL_RXRESET_BIT])
                            begin
                                rd_ptr_next = '0;
                                wr_ptr_next = '0;
                                fill_next   = '0;
                            end
                            ctrl_next = q_item.wdata & ~i2cm_pkg::CTL_MOMENT;
                        end
                        i2cm_pkg::SEL_STAT:
                        begin
                            stat_next = stat_reg & ~(q_item.wdata & i2cm_pkg::ST_W1C);
                        end
                        i2cm_pkg::SEL_CFG:
                        begin
                            cfg_next = q_item.wdata;
                        end
                        i2cm_pkg::SEL_CMD:
                        begin
                            if (ctrl_reg[i2cm_pkg::CTL_ENABLE_BIT])
                            begin
                                priority case (cmd_code)
                                    i2cm_pkg::CMD_START:
                                    begin
                                        bus_cmd_next  = i2cm_pkg::BUS_START;
                                        bus_data_next = q_item.wdata[7:0];
                                        pend_next     = PEND_START;
                                    end
                                    i2cm_pkg::CMD_SEND:
                                    begin
                                        bus_cmd_next  = i2cm_pkg::BUS_SEND;
                                        bus_data_next = q_item.wdata[7:0];
                                        pend_next     = PEND_SEND;
                                    end
                                    i2cm_pkg::CMD_RECV:
                                    begin
                                        bus_cmd_next  = i2cm_pkg::BUS_RECV;
                                        bus_data_next = q_item.wdata[7:0];
                                        pend_next     = PEND_RECV;
                                    end
                                    i2cm_pkg::CMD_STOP:
                                    begin
                                        bus_cmd_next = i2cm_pkg::BUS_STOP;
                                        stat_next    = (stat_reg | i2cm_pkg::ST_STOP
                                            | i2cm_pkg::ST_END) & ~i2cm_pkg::ST_BUSY;
                                        pend_next    = PEND_NONE;
                                    end
                                    default:
                                    begin
                                        pend_next = pend_reg;
                                    end
                                endcase
                            end
                        end
                        default:
                        begin
                            ctrl_next = ctrl_reg;
                        end
                    endcase
                end
                i2cm_pkg::OP_ACK:
                begin
                    unique case (pend_reg)
                        PEND_START:
                        begin
                            stat_next = stat_reg | (q_item.nack ? i2cm_pkg::ST_NACK
                                                                : i2cm_pkg::ST_BUSY);
                            pend_next = PEND_NONE;
                        end
                        PEND_SEND:
                        begin
                            if (q_item.nack)
                            begin
                                stat_next = stat_reg | i2cm_pkg::ST_NACK;
                            end
                            pend_next = PEND_NONE;
                        end
                        default:
                        begin
                            pend_next = pend_reg;
                        end
                    endcase
                end
                i2cm_pkg::OP_BYTE:
                begin
                    if (!fill_full)
                    begin
                        wr_en       = 1'b1;
                        wr_ptr_next = wr_ptr_inc;
                        fill_next   = fill_reg + FILL_W'(1);
                    end
                end
                default:
                begin
                    pend_next = pend_reg;
                end
            endcase
        end

        if (fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg      <= '0;
            stat_reg      <= '0;
            cfg_reg       <= '0;
            pend_reg      <= PEND_NONE;
            rd_ptr_reg    <= '0;
            wr_ptr_reg    <= '0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
            read_data_reg <= '0;
            bus_cmd_reg   <= i2cm_pkg::BUS_NONE;
            bus_data_reg  <= '0;
            pop_reg       <= 1'b0;
        end
        else
        begin
            ctrl_reg      <= ctrl_next;
            stat_reg      <= stat_next;
            cfg_reg       <= cfg_next;
            pend_reg      <= pend_next;
            rd_ptr_reg    <= rd_ptr_next;
            wr_ptr_reg    <= wr_ptr_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
            read_data_reg <= read_data_next;
            bus_cmd_reg   <= bus_cmd_next;
            bus_data_reg  <= bus_data_next;
            pop_reg       <= pop_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            rx_mem[wr_ptr_reg] <= q_item.rx_byte;
        end
        if (pop_en)
        begin
            mem_q_reg <= rx_mem[rd_ptr_reg];
        end
    end

    assign out_valid = out_valid_reg;
    assign read_data = pop_reg ? {24'd0, mem_q_reg} : read_data_reg;
    assign bus_cmd   = bus_cmd_reg;
    assign bus_data  = bus_data_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(RX_DEPTH))
        else $error("receive FIFO fill count exceeds its depth");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop_en |-> !fill_empty && !wr_en)
        else $error("receive FIFO popped while empty or during a write");

    a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && q_item.kind == i2cm_pkg::OP_BYTE && fill_full)
        |=> fill_reg == FILL_W'(RX_DEPTH))
        else $error("byte received into a full FIFO changed the fill count");

    a_start_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && bus_cmd_next == i2cm_pkg::BUS_START) |=> pend_reg == PEND_START)
        else $error("start request did not leave a start pending");

    a_stop_clears_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && bus_cmd_next == i2cm_pkg::BUS_STOP)
        |=> (stat_reg & i2cm_pkg::ST_BUSY) == 32'd0 && pend_reg == PEND_NONE)
        else $error("stop request left busy flags or a pending command");

endmodule

`default_nettype wire

[src/i2c_master_command_fifo_regs.sv]
// Top level of the I2C master register front end.
// Instantiates i2cm_front and i2cm_back; depends on i2cm_pkg.
//
// Each request is a register read, a register write, a bus acknowledge
// reply or a received bus byte, and produces exactly one response holding
// the read value and any bus request. Requests are decoded and queued in a
// two-entry queue, then executed one per cycle against the register state
// and the receive FIFO, so one request per clock is sustained while
// out_ready stays high; each response is registered after its request
// leaves the queue and is held until out_ready is high. The receive FIFO is
// a RX_DEPTH-byte memory with a registered read port, needs no clearing
// after reset, and a write of control bit 9 empties it.
`default_nettype none

module i2c_master_command_fifo_regs #(
    parameter int RX_DEPTH = 256
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  op,
    input  wire logic [15:0] reg_offset,
    input  wire logic [31:0] write_data,
    input  wire logic        bus_nack,
    input  wire logic [7:0]  bus_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      read_data,
    output logic [2:0]       bus_cmd,
    output logic [7:0]       bus_data
);

    logic            q_valid;
    logic            q_pop;
    i2cm_pkg::item_t q_item;

    i2cm_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .op         (op),
        .reg_offset (reg_offset),
        .write_data (write_data),
        .bus_nack   (bus_nack),
        .bus_byte   (bus_byte),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop)
    );

    i2cm_back #(
        .RX_DEPTH (RX_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .read_data (read_data),
        .bus_cmd   (bus_cmd),
        .bus_data  (bus_data)
    );

endmodule

`default_nettype wire

[tb/i2c_master_command_fifo_regs_test.sv]
// Self-checking testbench for the I2C master register front end.
// Drives register accesses and bus replies, and checks every response
// against a behavioral model. Depends on i2cm_pkg and i2c_master_command_fifo_regs.
`timescale 1ns / 100ps

module i2c_master_command_fifo_regs_test;

    localparam int RX_DEPTH    = 256;
    localparam int PTR_W       = $clog2(RX_DEPTH);
    localparam int CYCLE_LIMIT = 400000;

    localparam logic [2:0] CMD_UNUSED = 3'd7;

    typedef enum logic [1:0] {
        PEND_NONE,
        PEND_START,
        PEND_SEND,
        PEND_RECV
    } pend_kind_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic [2:0]  bus_cmd;
        logic [7:0]  bus_data;
    } resp_t;

    logic                clk;
    logic                rst_n      = 1'b0;
    logic                in_valid   = 1'b0;
    logic                in_ready;
    i2cm_pkg::op_kind_t  op         = i2cm_pkg::OP_READ;
    logic [15:0]         reg_offset = '0;
    logic [31:0]         write_data = '0;
    logic                bus_nack   = 1'b0;
    logic [7:0]          bus_byte   = '0;
    logic                out_valid;
    logic                out_ready  = 1'b0;
    logic [31:0]         read_data;
    logic [2:0]          bus_cmd;
    logic [7:0]          bus_data;

    logic [31:0]      model_ctrl;
    logic [31:0]      model_status;
    logic [31:0]      model_cfg;
    logic [7:0]       model_rx_mem [RX_DEPTH];
    logic [PTR_W-1:0] model_rx_rd_ptr;
    logic [PTR_W:0]   model_rx_count;
    pend_kind_t       model_pend;

    resp_t       pending_responses[$];
    int          error_count = 0;
    int          cycle_count = 0;
    int unsigned burst_left  = 0;
    bit          sender_idle_on = 1'b1;

    i2c_master_command_fifo_regs #(
        .RX_DEPTH(RX_DEPTH)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .op(op),
        .reg_offset(reg_offset),
        .write_data(write_data),
        .bus_nack(bus_nack),
        .bus_byte(bus_byte),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .read_data(read_data),
        .bus_cmd(bus_cmd),
        .bus_data(bus_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic resp_t predict_response(input i2cm_pkg::op_kind_t kind,
                                               input logic [15:0] off,
                                               input logic [31:0] wd, input logic nack,
                                               input logic [7:0] rx_b);
        resp_t            r;
        logic [PTR_W-1:0] wr_idx;
        r = '0;
        case (kind)
            i2cm_pkg::OP_READ:
            begin
                case (off)
                    i2cm_pkg::OFF_VERID: r.read_data = i2cm_pkg::VERID_VAL;
                    i2cm_pkg::OFF_PARAM: r.read_data = i2cm_pkg::PARAM_VAL;
                    i2cm_pkg::OFF_CTRL:  r.read_data = model_ctrl;
                    i2cm_pkg::OFF_STAT:
                    begin
                        r.read_data = model_status | i2cm_pkg::ST_TXREADY;
                        if (model_rx_count != 0)
                            r.read_data = r.read_data | i2cm_pkg::ST_RXREADY;
                    end
                    i2cm_pkg::OFF_CFG:   r.read_data = model_cfg;
                    i2cm_pkg::OFF_FSR:
                        r.read_data = (32'(model_rx_count) & i2cm_pkg::FSR_MASK) << 16;
                    i2cm_pkg::OFF_RDR:
                    begin
                        if (model_rx_count == 0)
                            r.read_data = i2cm_pkg::RX_EMPTY_VAL;
                        else
                        begin
                            r.read_data = {24'd0, model_rx_mem[model_rx_rd_ptr]};
                            model_rx_rd_ptr = model_rx_rd_ptr + 1'b1;
                            model_rx_count = model_rx_count - 1'b1;
                        end
                    end
                    default:   r.read_data = '0;
                endcase
            end
            i2cm_pkg::OP_WRITE:
            begin
                case (off)
                    i2cm_pkg::OFF_CTRL:
                    begin
                        if (wd[i2cm_pkg::CTL_RXRESET_BIT])
                        begin
                            model_rx_rd_ptr = '0;
                            model_rx_count = '0;
                        end
                        model_ctrl = wd & ~i2cm_pkg::CTL_MOMENT;
                    end
                    i2cm_pkg::OFF_STAT: model_status = model_status & ~(wd & i2cm_pkg::ST_W1C);
                    i2cm_pkg::OFF_CFG:  model_cfg = wd;
                    i2cm_pkg::OFF_CMD:
                    begin
                        if (model_ctrl[i2cm_pkg::CTL_ENABLE_BIT])
                        begin
                            case (wd[10:8])
                                i2cm_pkg::CMD_START:
                                begin
                                    r.bus_cmd = i2cm_pkg::BUS_START;
                                    r.bus_data = wd[7:0];
                                    model_pend = PEND_START;
                                end
                                i2cm_pkg::CMD_SEND:
                                begin
                                    r.bus_cmd = i2cm_pkg::BUS_SEND;
                                    r.bus_data = wd[7:0];
                                    model_pend = PEND_SEND;
                                end
                                i2cm_pkg::CMD_RECV:
                                begin
                                    r.bus_cmd = i2cm_pkg::BUS_RECV;
                                    r.bus_data = wd[7:0];
                                    model_pend = PEND_RECV;
                                end
                                i2cm_pkg::CMD_STOP:
                                begin
                                    r.bus_cmd = i2cm_pkg::BUS_STOP;
                                    model_status = (model_status | i2cm_pkg::ST_STOP
                                        | i2cm_pkg::ST_END) & ~i2cm_pkg::ST_BUSY;
                                    model_pend = PEND_NONE;
                                end
                                default: ;
                            endcase
                        end
                    end
                    default: ;
                endcase
            end
            i2cm_pkg::OP_ACK:
            begin
                if (model_pend == PEND_START)
                begin
                    model_status = model_status
                        | (nack ? i2cm_pkg::ST_NACK : i2cm_pkg::ST_BUSY);
                    model_pend = PEND_NONE;
                end
                else if (model_pend == PEND_SEND)
                begin
                    if (nack)
                        model_status = model_status | i2cm_pkg::ST_NACK;
                    model_pend = PEND_NONE;
                end
            end
            default:
            begin
                if (model_rx_count < RX_DEPTH)
                begin
                    wr_idx = model_rx_rd_ptr + model_rx_count[PTR_W-1:0];
                    model_rx_mem[wr_idx] = rx_b;
                    model_rx_count = model_rx_count + 1'b1;
                end
            end
        endcase
        return r;
    endfunction

    task automatic send_request(input i2cm_pkg::op_kind_t req_op, input logic [15:0] req_off,
                                input logic [31:0] req_wdata, input logic req_nack,
                                input logic [7:0] req_byte);
        int unsigned gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = sender_idle_on ? $urandom_range(1, 6) : 0;
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid   <= 1'b1;
        op         <= req_op;
        reg_offset <= req_off;
        write_data <= req_wdata;
        bus_nack   <= req_nack;
        bus_byte   <= req_byte;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_responses.push_back(
            predict_response(req_op, req_off, req_wdata, req_nack, req_byte));
    endtask

    task automatic send_read(input logic [15:0] off);
        send_request(i2cm_pkg::OP_READ, off, $urandom, 1'($urandom), 8'($urandom));
    endtask

    task automatic send_write(input logic [15:0] off, input logic [31:0] wd);
        send_request(i2cm_pkg::OP_WRITE, off, wd, 1'($urandom), 8'($urandom));
    endtask

    task automatic send_ack(input logic nack);
        send_request(i2cm_pkg::OP_ACK, 16'($urandom), $urandom, nack, 8'($urandom));
    endtask

    task automatic send_rx_byte(input logic [7:0] b);
        send_request(i2cm_pkg::OP_BYTE, 16'($urandom), $urandom, 1'($urandom), b);
    endtask

    function automatic logic [31:0] cmd_word(input logic [2:0] code, input logic [7:0] data);
        logic [31:0] w;
        w = $urandom;
        w[10:8] = code;
        w[7:0] = data;
        return w;
    endfunction

    function automatic logic [15:0] pick_offset();
        case ($urandom_range(0, 11))
            0:       return i2cm_pkg::OFF_VERID;
            1:       return i2cm_pkg::OFF_PARAM;
            2:       return i2cm_pkg::OFF_CTRL;
            3:       return i2cm_pkg::OFF_STAT;
            4:       return i2cm_pkg::OFF_IER;
            5:       return i2cm_pkg::OFF_CFG;
            6:       return i2cm_pkg::OFF_FSR;
            7:       return i2cm_pkg::OFF_CMD;
            8:       return i2cm_pkg::OFF_RDR;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic test_register_map();
        send_read(i2cm_pkg::OFF_VERID);
        send_read(i2cm_pkg::OFF_PARAM);
        send_read(i2cm_pkg::OFF_STAT);
        send_read(i2cm_pkg::OFF_IER);
        send_read(i2cm_pkg::OFF_CFG);
        send_read(i2cm_pkg::OFF_FSR);
        send_read(i2cm_pkg::OFF_RDR);
        send_read(16'hFFFF);
        send_write(i2cm_pkg::OFF_CMD, {21'h1FFFFF, i2cm_pkg::CMD_START, 8'hA5});
    endtask

    task automatic test_control_and_config();
        send_write(i2cm_pkg::OFF_CTRL, 32'hFFFF_FFFF);
        send_read(i2cm_pkg::OFF_CTRL);
        send_write(i2cm_pkg::OFF_CFG, 32'hFFFF_FFFF);
    endtask

    task automatic test_bus_commands();
        send_write(i2cm_pkg::OFF_CMD, {21'h1FFFFF, i2cm_pkg::CMD_START, 8'hFF});
        send_ack(1'b0);
        send_write(i2cm_pkg::OFF_CMD, {21'h0, i2cm_pkg::CMD_SEND, 8'h00});
        send_ack(1'b1);
        send_write(i2cm_pkg::OFF_CMD, {21'h0, CMD_UNUSED, 8'h5A});
        send_ack(1'b1);
        send_write(i2cm_pkg::OFF_CMD, {21'h0, i2cm_pkg::CMD_RECV, 8'hFF});
        send_ack(1'b0);
    endtask

    task automatic test_rx_fifo();
        send_rx_byte(8'h00);
        send_rx_byte(8'hFF);
        send_read(i2cm_pkg::OFF_STAT);
        send_read(i2cm_pkg::OFF_RDR);
        send_read(i2cm_pkg::OFF_RDR);
    endtask

    task automatic test_status_clear();
        send_write(i2cm_pkg::OFF_CMD, {21'h1FFFFF, i2cm_pkg::CMD_STOP, 8'hFF});
        send_read(i2cm_pkg::OFF_STAT);
        send_write(i2cm_pkg::OFF_STAT, 32'hFFFF_FFFF);
        send_read(i2cm_pkg::OFF_STAT);
    endtask

    task automatic test_bus_transactions(input int sessions);
        logic [31:0] ctrl;
        int unsigned count;
        for (int s = 0; s < sessions; s++)
        begin
            sender_idle_on = (s % 4 != 3);
            ctrl = $urandom;
            ctrl[i2cm_pkg::CTL_ENABLE_BIT] = ($urandom_range(0, 7) != 0);
            if ($urandom_range(0, 3) != 0)
                ctrl[i2cm_pkg::CTL_RXRESET_BIT] = 1'b0;
            send_write(i2cm_pkg::OFF_CTRL, ctrl);
            send_write(i2cm_pkg::OFF_CMD, cmd_word(i2cm_pkg::CMD_START, 8'($urandom)));
            send_ack($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 1) != 0)
            begin
                count = $urandom_range(0, 7);
                send_write(i2cm_pkg::OFF_CMD, cmd_word(i2cm_pkg::CMD_RECV, 8'(count)));
                if ($urandom_range(0, 1) != 0)
                    send_ack(1'($urandom));
                repeat (count + 1) send_rx_byte(8'($urandom));
                send_read(i2cm_pkg::OFF_FSR);
                repeat (count + 1) send_read(i2cm_pkg::OFF_RDR);
            end
            else
            begin
                repeat ($urandom_range(1, 4))
                begin
                    send_write(i2cm_pkg::OFF_CMD,
                               cmd_word(i2cm_pkg::CMD_SEND, 8'($urandom)));
                    send_ack($urandom_range(0, 5) == 0);
                end
            end
            send_read(i2cm_pkg::OFF_STAT);
            if ($urandom_range(0, 5) != 0)
                send_write(i2cm_pkg::OFF_CMD, cmd_word(i2cm_pkg::CMD_STOP, 8'($urandom)));
            send_read(i2cm_pkg::OFF_STAT);
            send_write(i2cm_pkg::OFF_STAT, $urandom);
        end
    endtask

    task automatic test_rx_overflow();
        logic [31:0] ctrl;
        sender_idle_on = 1'b1;
        while (model_rx_count != 0)
            send_read(i2cm_pkg::OFF_RDR);
        repeat (RX_DEPTH + 4) send_rx_byte(8'($urandom));
        send_read(i2cm_pkg::OFF_FSR);
        send_read(i2cm_pkg::OFF_STAT);
        repeat (RX_DEPTH - 40) send_read(i2cm_pkg::OFF_RDR);
        ctrl = $urandom;
        ctrl[i2cm_pkg::CTL_ENABLE_BIT] = 1'b1;
        ctrl[i2cm_pkg::CTL_RXRESET_BIT] = 1'b1;
        send_write(i2cm_pkg::OFF_CTRL, ctrl);
        send_read(i2cm_pkg::OFF_FSR);
        send_read(i2cm_pkg::OFF_RDR);
    endtask

    task automatic test_random_noise(input int count);
        for (int i = 0; i < count; i++)
        begin
            if (i % 50 == 0)
                sender_idle_on = ($urandom_range(0, 3) != 0);
            send_request(i2cm_pkg::op_kind_t'($urandom_range(0, 3)), pick_offset(), $urandom,
                         1'($urandom), 8'($urandom));
        end
    endtask

    task automatic report_mismatch(input string field, input logic [31:0] exp_val,
                                   input logic [31:0] act_val);
        error_count++;
        if (error_count <= 10)
            $display("Mismatch on %s at cycle %0d: expected %h, got %h",
                     field, cycle_count, exp_val, act_val);
    endtask

    always @(posedge clk)
    begin : check_responses
        resp_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_responses.size() == 0)
            begin
                error_count++;
                if (error_count <= 10)
                    $display("Response at cycle %0d with no request outstanding", cycle_count);
            end
            else
            begin
                want = pending_responses.pop_front();
                if (read_data !== want.read_data)
                    report_mismatch("read_data", want.read_data, read_data);
                if (bus_cmd !== want.bus_cmd)
                    report_mismatch("bus_cmd", 32'(want.bus_cmd), 32'(bus_cmd));
                if (bus_data !== want.bus_data)
                    report_mismatch("bus_data", 32'(want.bus_data), 32'(bus_data));
            end
        end
    end

    initial
    begin : ready_pattern
        logic [15:0] pattern;
        int unsigned phase;
        pattern = '1;
        phase = 0;
        forever
        begin
            @(posedge clk);
            if (phase % 64 == 0)
                pattern = ($urandom_range(0, 2) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
            out_ready <= pattern[phase[3:0]];
            phase++;
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        model_ctrl = '0;
        model_status = '0;
        model_cfg = '0;
        model_rx_rd_ptr = '0;
        model_rx_count = '0;
        model_pend = PEND_NONE;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_register_map();
        test_control_and_config();
        test_bus_commands();
        test_rx_fifo();
        test_status_clear();
        test_bus_transactions(28);
        test_rx_overflow();
        test_random_noise(230);
        in_valid <= 1'b0;
        while (pending_responses.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

[i2c_master_command_fifo_regs.f]
src/i2cm_pkg.sv
src/i2cm_front.sv
src/i2cm_back.sv
src/i2c_master_command_fifo_regs.sv
tb/i2c_master_command_fifo_regs_test.sv
